// ----- hdl/rwrf_pkg.sv -----
// Shared types, constants and helpers for the window rank filter.
package rwrf_pkg;

  localparam int PIXW       = 24;
  localparam int KEYW       = 8;
  localparam int HW         = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_DW     = 13;
  localparam int CFG_IW     = 2;
  localparam int RECIP3     = 683;
  localparam int RECIP_SH   = 11;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WSIZE  = 2'd2,
    REG_RANK   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DRAIN,
    ST_SELECT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [KEYW-1:0] key;
    logic [PIXW-1:0] pix;
  } cell_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

  // Mean of the three channels, divided by 3 through a reciprocal multiply.
  function automatic logic [KEYW-1:0] key_of(input logic [PIXW-1:0] p);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
    prod = 20'(sum) * 20'(RECIP3);
    return prod[RECIP_SH +: KEYW];
  endfunction

endpackage

// ----- hdl/rwrf_if.sv -----
// Handshake interfaces for the pixel, result and register channels.
interface rwrf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  modport source (output valid, action, chan0, chan1, chan2, input ready);
  modport sink (input valid, action, chan0, chan1, chan2, output ready);
endinterface

interface rwrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_chan0;
  logic [7:0] out_chan1;
  logic [7:0] out_chan2;
  logic       frame_end;
  logic       config_error;
  modport source (output valid, out_chan0, out_chan1, out_chan2, frame_end, config_error,
                  input ready);
  modport sink (input valid, out_chan0, out_chan1, out_chan2, frame_end, config_error,
                output ready);
endinterface

interface rwrf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rwrf_pkg::CFG_IW-1:0]  index;
  logic [rwrf_pkg::CFG_DW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/rwrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rwrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/rwrf_cell.sv -----
// One cell of the sorted insertion chain: holds a key and its pixel.
module rwrf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rwrf_pkg::cell_ctl_t ctl,
  input  rwrf_pkg::cell_t     new_d,
  input  rwrf_pkg::cell_t     prev_d,
  input  logic                prev_gt,
  input  rwrf_pkg::cell_t     next_d,
  output rwrf_pkg::cell_t     own_d,
  output logic                gt
);
  import rwrf_pkg::*;

  cell_t own_r, own_nxt;

  // Equal keys stay ahead of the newcomer so scan order is kept on ties.
  assign gt    = !own_r.valid || (own_r.key > new_d.key);
  assign own_d = own_r;

  always_comb begin
    own_nxt = own_r;
    if (ctl.clear) begin
      own_nxt.valid = 1'b0;
    end else if (ctl.insert && gt) begin
      own_nxt = prev_gt ? prev_d : new_d;
    end else if (ctl.shift) begin
      own_nxt = next_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r.valid <= 1'b0;
    end else begin
      own_r.valid <= own_nxt.valid;
    end
    own_r.key <= own_nxt.key;
    own_r.pix <= own_nxt.pix;
  end
endmodule

// ----- hdl/rgb_window_rank_filter.sv -----
// Top level of the RGB window rank filter.
// With no result the block stays idle after taking a word; with a result, the word starts the
// window gather reads, then a drain state, then selection shifts until the ranked cell heads the chain.
// One item at a time: no new word is taken until the result word has been taken at the output.
// Results lag pixels by d*W + d items, d = ws - 1 - ws/2; flush words drain the frame.
// Synchronous active-low reset restores default registers and clears counters, not the store.
module rgb_window_rank_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input logic clk,
  input logic rst_n,
  rwrf_in_if.sink    in_ch,
  rwrf_out_if.source out_ch,
  rwrf_cfg_if.sink   cfg_ch
);
  import rwrf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int WSW   = $clog2(MAX_WINDOW + 1);
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int NC    = MAX_WINDOW * MAX_WINDOW;
  localparam int NW    = $clog2(NC + 1);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = WW + WSW;
  localparam int SEENW = 23;

  // configuration
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  wsize_r;
  logic [5:0]  rank_r;
  logic        cfg_acc;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [WSW-1:0] ws_eff, off, dd;
  logic [LW-1:0]  lat;
  logic [5:0]     ws_sq_raw;
  logic           cfg_err;

  always_comb begin
    if (width_r == 11'd0) w_eff = WW'(1);
    else if (width_r > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == 13'd0) h_eff = HW'(1);
    else if (height_r > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_r);
    if (wsize_r == 3'd0) ws_eff = WSW'(1);
    else if (wsize_r > MAX_WINDOW) ws_eff = WSW'(MAX_WINDOW);
    else ws_eff = WSW'(wsize_r);
  end

  assign off       = ws_eff >> 1;
  assign dd        = ws_eff - WSW'(1) - off;
  assign lat       = LW'(dd) * LW'(w_eff) + LW'(dd);
  assign ws_sq_raw = 6'(wsize_r) * 6'(wsize_r);
  assign cfg_err   = (wsize_r <= 3'd1) || (11'(wsize_r) >= width_r)
                  || (13'(wsize_r) >= height_r) || (rank_r == 6'd0)
                  || (rank_r >= ws_sq_raw) || (width_r > MAX_WIDTH)
                  || (height_r > MAX_HEIGHT) || (wsize_r > MAX_WINDOW);

  // state machine
  state_t state_r, state_nxt;
  logic   in_acc, out_acc, take, go_work, last_elem, sel_hit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!cfg_acc && go_work) state_nxt = ST_GATHER;
      ST_GATHER: if (last_elem) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_SELECT;
      ST_SELECT: if (sel_hit) state_nxt = ST_OUT;
      ST_OUT:    if (out_acc) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  logic      idle, gathering, selecting;
  always_comb begin
    idle      = 1'b0;
    gathering = 1'b0;
    selecting = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE:   idle = 1'b1;
      ST_GATHER: gathering = 1'b1;
      ST_SELECT: selecting = 1'b1;
      ST_OUT:    out_ch.valid = 1'b1;
      default:   idle = 1'b0;
    endcase
  end

  assign cfg_ch.ready = idle;
  assign in_ch.ready  = idle && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      wsize_r  <= 3'd3;
      rank_r   <= 6'd4;
    end else if (cfg_acc) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_WIDTH:  width_r  <= cfg_ch.data[10:0];
        REG_HEIGHT: height_r <= cfg_ch.data[12:0];
        REG_WSIZE:  wsize_r  <= cfg_ch.data[2:0];
        REG_RANK:   rank_r   <= cfg_ch.data[5:0];
        default:    rank_r   <= rank_r;
      endcase
    end
  end

  // input and output side counters
  logic [HW-1:0]    in_row_r, out_row_r;
  logic [CW-1:0]    in_col_r, out_col_r;
  logic [SW-1:0]    in_slot_r, out_slot_r;
  logic [SEENW-1:0] seen_r;
  logic [SEENW-1:0] seen_inc;
  logic [CW:0]      in_col_inc, out_col_inc;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             frame_done;

  assign take       = in_row_r < h_eff;
  assign seen_inc   = seen_r + SEENW'(1);
  assign go_work    = in_acc && !(take && in_ch.action) && (seen_inc > SEENW'(lat));
  assign wr_en      = in_acc && take && !in_ch.action;
  assign wr_addr    = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  assign in_col_inc = (CW+1)'(in_col_r) + (CW+1)'(1);
  assign out_col_inc = (CW+1)'(out_col_r) + (CW+1)'(1);

  // window scan
  logic [WSW-1:0]       k_r, l_r;
  logic signed [HW+1:0] rr;
  logic signed [CW+1:0] cc;
  logic [SW+1:0]        st;
  logic [SW-1:0]        slot;
  logic                 in_img, rd_en, rd_pend_r;
  logic [AW-1:0]        rd_addr;
  logic [PIXW-1:0]      rd_data;
  logic [NW-1:0]        el_r;

  always_comb begin
    rr = $signed((HW+2)'(out_row_r)) - $signed((HW+2)'(off)) + $signed((HW+2)'(l_r));
    cc = $signed((CW+2)'(out_col_r)) - $signed((CW+2)'(off)) + $signed((CW+2)'(k_r));
    in_img = (rr >= 0) && (rr < $signed((HW+2)'(h_eff)))
          && (cc >= 0) && (cc < $signed((CW+2)'(w_eff)));
    st = (SW+2)'(out_slot_r) + (SW+2)'(MAX_WINDOW) - (SW+2)'(off) + (SW+2)'(l_r);
    if (st >= (SW+2)'(2 * MAX_WINDOW)) st = st - (SW+2)'(2 * MAX_WINDOW);
    else if (st >= (SW+2)'(MAX_WINDOW)) st = st - (SW+2)'(MAX_WINDOW);
    slot = st[SW-1:0];
    rd_addr = AW'(slot) * AW'(MAX_WIDTH) + AW'(cc[CW-1:0]);
  end

  assign rd_en     = gathering && in_img;
  assign last_elem = (k_r == ws_eff - WSW'(1)) && (l_r == ws_eff - WSW'(1));

  rwrf_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_ch.chan2, in_ch.chan1, in_ch.chan0}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // rank selection
  logic signed [NW+7:0] pos_s;
  logic [NW-1:0]        pos, sel_cnt_r;
  logic [6:0]           ws_sq;

  assign ws_sq = 7'(ws_eff) * 7'(ws_eff);
  always_comb begin
    pos_s = $signed((NW+8)'(rank_r)) - $signed((NW+8)'(ws_sq)) + $signed((NW+8)'(el_r));
    if (pos_s < 0) pos = '0;
    else if (pos_s >= $signed((NW+8)'(el_r))) pos = el_r - NW'(1);
    else pos = pos_s[NW-1:0];
  end
  assign sel_hit = selecting && (sel_cnt_r == pos);

  // cell chain
  cell_ctl_t ctl;
  cell_t     new_d;
  cell_t     cells [NC];
  logic      gts   [NC];

  assign ctl.clear  = idle;
  assign ctl.insert = rd_pend_r;
  assign ctl.shift  = selecting && !sel_hit;
  assign new_d      = '{valid: 1'b1, key: key_of(rd_data), pix: rd_data};

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cell_t nxt_c, prv_c;
    logic  prv_gt;
    if (i == 0) begin : g_head
      assign prv_c  = new_d;
      assign prv_gt = 1'b0;
    end else begin : g_body
      assign prv_c  = cells[i-1];
      assign prv_gt = gts[i-1];
    end
    if (i == NC - 1) begin : g_tail
      assign nxt_c = '0;
    end else begin : g_mid
      assign nxt_c = cells[i+1];
    end
    rwrf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .new_d   (new_d),
      .prev_d  (prv_c),
      .prev_gt (prv_gt),
      .next_d  (nxt_c),
      .own_d   (cells[i]),
      .gt      (gts[i])
    );
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      l_r       <= '0;
      rd_pend_r <= 1'b0;
      el_r      <= '0;
      sel_cnt_r <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (idle) begin
        k_r       <= '0;
        l_r       <= '0;
        el_r      <= '0;
        sel_cnt_r <= '0;
      end else begin
        if (gathering) begin
          if (l_r == ws_eff - WSW'(1)) begin
            l_r <= '0;
            k_r <= k_r + WSW'(1);
          end else begin
            l_r <= l_r + WSW'(1);
          end
        end
        if (rd_pend_r) el_r <= el_r + NW'(1);
        if (ctl.shift) sel_cnt_r <= sel_cnt_r + NW'(1);
      end
    end
  end

  // counters
  assign frame_done = (out_col_inc >= (CW+1)'(w_eff)) && (out_row_r + HW'(1) >= h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc || (sel_hit && frame_done)) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      seen_r     <= '0;
    end else begin
      if (in_acc && !(take && in_ch.action)) begin
        seen_r <= seen_inc;
        if (take) begin
          if (in_col_inc >= (CW+1)'(w_eff)) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + HW'(1);
            in_slot_r <= (in_slot_r == SW'(MAX_WINDOW - 1)) ? '0 : in_slot_r + SW'(1);
          end else begin
            in_col_r <= in_col_inc[CW-1:0];
          end
        end
      end
      if (sel_hit) begin
        if (out_col_inc >= (CW+1)'(w_eff)) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + HW'(1);
          out_slot_r <= (out_slot_r == SW'(MAX_WINDOW - 1)) ? '0 : out_slot_r + SW'(1);
        end else begin
          out_col_r <= out_col_inc[CW-1:0];
        end
      end
    end
  end

  // result register
  logic [PIXW-1:0] res_pix_r;
  logic            res_end_r, res_err_r;

  always_ff @(posedge clk) begin
    if (sel_hit) begin
      res_pix_r <= cells[0].pix;
      res_end_r <= frame_done;
      res_err_r <= cfg_err;
    end
  end

  assign out_ch.out_chan0    = res_pix_r[7:0];
  assign out_ch.out_chan1    = res_pix_r[15:8];
  assign out_ch.out_chan2    = res_pix_r[23:16];
  assign out_ch.frame_end    = res_end_r;
  assign out_ch.config_error = res_err_r;
endmodule

// ----- hdl/rwrf_checker.sv -----
// Port-level checks for the window rank filter, bound to the top level.
module rwrf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid) else $error("config open while result pending");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule

bind rgb_window_rank_filter rwrf_checker u_rwrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the RGB window rank filter.
`timescale 1ns / 100ps

module tb;
  import rwrf_pkg::*;

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       fe;
    logic       err;
  } rank_pix_t;

  // Predicts the filtered pixel stream and checks the results against it.
  class rank_scoreboard;
    int unsigned width_r, height_r, wsize_r, rank_r;
    logic [23:0] line_store [7][1024];
    int unsigned in_row, in_col, out_row, out_col, seen;
    rank_pix_t   due_q[$];
    int          errors, results, frames;

    function new();
      width_r  = 640;
      height_r = 480;
      wsize_r  = 3;
      rank_r   = 4;
      clear();
    endfunction

    function void clear();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
      seen    = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int unsigned eff_w();
      return width_r == 0 ? 1 : (width_r > 1024 ? 1024 : width_r);
    endfunction

    function int unsigned eff_h();
      return height_r == 0 ? 1 : (height_r > MAX_HEIGHT ? MAX_HEIGHT : height_r);
    endfunction

    function int unsigned eff_ws();
      return wsize_r == 0 ? 1 : (wsize_r > 7 ? 7 : wsize_r);
    endfunction

    function logic bad_settings();
      if (wsize_r <= 1 || wsize_r >= width_r || wsize_r >= height_r) return 1'b1;
      if (rank_r == 0 || rank_r >= wsize_r * wsize_r) return 1'b1;
      if (width_r > 1024 || height_r > MAX_HEIGHT || wsize_r > 7) return 1'b1;
      return 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
      case (idx)
        REG_WIDTH:  width_r = v[10:0];
        REG_HEIGHT: height_r = v[12:0];
        REG_WSIZE:  wsize_r = v[2:0];
        REG_RANK:   rank_r = v[5:0];
        default: ;
      endcase
      // any write restarts the frame
      clear();
    endfunction

    function void note_word(logic act, logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int unsigned w, h, ws, off, d, lat, el, rk, k, l, i, j;
      int          rr, cc, pos;
      logic [23:0] px [49];
      int unsigned ky [49];
      logic [23:0] sel;
      rank_pix_t   res;
      w   = eff_w();
      h   = eff_h();
      ws  = eff_ws();
      off = ws / 2;
      d   = ws - 1 - off;
      lat = d * w + d;
      if (in_row < h) begin
        if (act) return;
        line_store[in_row % 7][in_col] = {c, b, a};
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      seen++;
      if (seen <= lat) return;
      el = 0;
      for (k = 0; k < ws; k++) begin
        for (l = 0; l < ws; l++) begin
          rr = int'(out_row) - int'(off) + int'(l);
          cc = int'(out_col) - int'(off) + int'(k);
          if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
            px[el] = line_store[rr % 7][cc];
            ky[el] = (px[el][7:0] + px[el][15:8] + px[el][23:16]) / 3;
            el++;
          end
        end
      end
      pos = int'(rank_r) - int'(ws * ws - el);
      if (pos < 0) pos = 0;
      if (el > 0 && pos >= int'(el)) pos = int'(el) - 1;
      sel = '0;
      for (i = 0; i < el; i++) begin
        rk = 0;
        for (j = 0; j < el; j++)
          if (ky[j] < ky[i] || (ky[j] == ky[i] && j < i)) rk++;
        if (rk == pos) begin
          sel = px[i];
          break;
        end
      end
      res.c0  = sel[7:0];
      res.c1  = sel[15:8];
      res.c2  = sel[23:16];
      res.err = bad_settings();
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      res.fe = (out_row >= h);
      if (res.fe) begin
        frames++;
        clear();
      end
      due_q = {due_q, res};
    endfunction

    function void check_result(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                               logic fe, logic err);
      rank_pix_t e;
      results++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result %h %h %h", a, b, c));
        return;
      end
      e = due_q.pop_front();
      if (a !== e.c0) report($sformatf("out_chan0 %h, want %h", a, e.c0));
      if (b !== e.c1) report($sformatf("out_chan1 %h, want %h", b, e.c1));
      if (c !== e.c2) report($sformatf("out_chan2 %h, want %h", c, e.c2));
      if (fe !== e.fe) report($sformatf("frame_end %b, want %b", fe, e.fe));
      if (err !== e.err) report($sformatf("config_error %b, want %b", err, e.err));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   burst;
  int   words;

  rwrf_in_if  in_ch ();
  rwrf_out_if out_ch ();
  rwrf_cfg_if cfg_ch ();

  rank_scoreboard sb = new();

  rgb_window_rank_filter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // result side: stall at random, check every word taken
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.out_chan0, out_ch.out_chan1, out_ch.out_chan2,
                      out_ch.frame_end, out_ch.config_error);
    end
  end

  task automatic send_word(logic act, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.chan0  <= a;
    in_ch.chan1  <= b;
    in_ch.chan2  <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(act, a, b, c);
    words++;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // drop valid once no further word follows
  task automatic stop_words();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    stop_words();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, int unsigned v, int unsigned fw);
    logic [CFG_DW-1:0] data;
    data = CFG_DW'(v);
    // set unused upper bits now and then; they must be masked off
    if ($urandom_range(0, 3) == 0)
      for (int b = fw; b < CFG_DW; b++) data[b] = $urandom_range(0, 1);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_all(int unsigned w, int unsigned h, int unsigned ws, int unsigned rk);
    settle();
    cfg_write(REG_WIDTH, w, 11);
    cfg_write(REG_HEIGHT, h, 13);
    cfg_write(REG_WSIZE, ws, 3);
    cfg_write(REG_RANK, rk, 6);
  endtask

  // Send words until the frame ends, or until the cut when abort is set; mix in stray flushes and late pixels.
  task automatic run_frame(bit abort);
    int          target, n, cut, hold;
    logic        act;
    target = sb.frames + 1;
    n      = 0;
    cut    = $urandom_range(1, 40);
    hold   = $urandom_range(0, 60);
    burst  = ($urandom_range(0, 3) == 0);
    while (sb.frames < target && !(abort && n == cut)) begin
      if (n == hold) begin
        stop_words();
        while (sb.due_q.size() != 0) @(posedge clk);
      end
      if (sb.in_row < sb.eff_h()) act = ($urandom_range(0, 19) == 0);
      else act = ($urandom_range(0, 19) != 0);
      send_word(act, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      n++;
    end
  endtask

  initial begin
    logic [7:0] dir_pix [9][3];
    int unsigned w, ws, start;
    dir_pix = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd1, 8'd2, 8'd0},
                '{8'd0, 8'd0, 8'd3}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
                '{8'd0, 8'd0, 8'd255}, '{8'd10, 8'd20, 8'd30}, '{8'd128, 8'd64, 8'd32}};
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = 1'b0;
    in_ch.chan0  = '0;
    in_ch.chan1  = '0;
    in_ch.chan2  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data  = '0;
    words        = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 3x3 frame with ties, extremes, an early flush and a late pixel.
    set_all(3, 3, 3, 4);
    for (int p = 0; p < 9; p++) begin
      send_word(1'b0, dir_pix[p][0], dir_pix[p][1], dir_pix[p][2]);
      if (p == 1) send_word(1'b1, 8'hff, 8'hff, 8'hff);
    end
    send_word(1'b0, 8'hff, 8'h00, 8'hff);
    repeat (3) send_word(1'b1, 8'h00, 8'h00, 8'h00);
    // zero rank on a 2x2 image: corners cut, rank clamps
    set_all(2, 2, 2, 0);
    for (int p = 0; p < 4; p++)
      send_word(1'b0, dir_pix[p + 5][0], dir_pix[p + 5][1], dir_pix[p + 5][2]);

    // Extreme settings; the large images are cut short.
    set_all(0, 0, 0, 0);
    run_frame(1'b0);
    set_all(2047, 2, 2, 1);
    run_frame(1'b1);
    set_all(1024, 2, 2, 3);
    run_frame(1'b1);
    set_all(2, 8191, 2, 1);
    run_frame(1'b1);
    set_all(8, 8, 7, 48);
    run_frame(1'b0);
    set_all(5, 4, 7, 63);
    run_frame(1'b0);

    // Random frames, mostly valid settings on small images.
    start = words;
    while (words - start < 650) begin
      w  = $urandom_range(2, 10);
      ws = $urandom_range(2, 7);
      settle();
      if ($urandom_range(0, 1)) cfg_write(REG_WIDTH, w, 11);
      if ($urandom_range(0, 1)) cfg_write(REG_HEIGHT, $urandom_range(2, 6), 13);
      if ($urandom_range(0, 1)) cfg_write(REG_WSIZE, ws, 3);
      cfg_write(REG_RANK, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(1, ws * ws - 1), 6);
      run_frame($urandom_range(0, 7) == 0);
    end

    settle();
    $display("covered %0d input words, %0d results, %0d complete frames",
             words, sb.results, sb.frames);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rwrf_pkg.sv
hdl/rwrf_if.sv
hdl/rwrf_ram.sv
hdl/rwrf_cell.sv
hdl/rgb_window_rank_filter.sv
hdl/rwrf_checker.sv
bench/tb.sv
